FILE: src/qcsc_pkg.sv
// qcsc_pkg: types and constants for the clip-space cull core.
// No dependencies; imported by every module of the block.
`default_nettype none
package qcsc_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned ProdW = 64;
  // Doubled corner component: sum of three 64-bit terms, plus a w-sum margin.
  localparam int unsigned CompW = 67;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [WordW-1:0] col0_x, col0_y, col0_z, col0_w;
    logic signed [WordW-1:0] col1_x, col1_y, col1_z, col1_w;
    logic signed [WordW-1:0] col3_x, col3_y, col3_z, col3_w;
  } qcsc_item_t;

  // Front-end result handed through the queue.
  typedef struct packed {
    logic                    trans_in;
    logic signed [ProdW-1:0] px_x, px_y, px_z, px_w;
    logic signed [ProdW-1:0] py_x, py_y, py_z, py_w;
    logic signed [ProdW-1:0] pt_x, pt_y, pt_z, pt_w;
  } qcsc_job_t;
endpackage
`default_nettype wire

FILE: src/qcsc_if.sv
// qcsc_if / qcsc_res_if: valid-ready channels of the cull core.
// Depends on qcsc_pkg.
`default_nettype none
interface qcsc_if import qcsc_pkg::*; ();
  logic       valid;
  logic       ready;
  qcsc_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qcsc_res_if;
  logic valid;
  logic ready;
  logic culled;
  modport source (output valid, output culled, input ready);
  modport sink   (input valid, input culled, output ready);
endinterface
`default_nettype wire

FILE: src/qcsc_front.sv
// qcsc_front: accepts items, tests the translation point, forms products.
// Depends on qcsc_pkg.
`default_nettype none
module qcsc_front import qcsc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire qcsc_item_t              in_data_i,
  input  wire logic signed [WordW-1:0] width_i,
  input  wire logic signed [WordW-1:0] height_i,
  output logic                         job_valid_o,
  input  wire logic                    job_ready_i,
  output qcsc_job_t                    job_o
);
  logic      valid_q;
  qcsc_job_t job_q, job_d;
  logic signed [WordW:0] nw;

  assign in_ready_o  = !valid_q || job_ready_i;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  always_comb begin
    nw = -{in_data_i.col3_w[WordW-1], in_data_i.col3_w};
    job_d.trans_in =
      (nw <= in_data_i.col3_x) && (in_data_i.col3_x <= in_data_i.col3_w) &&
      (nw <= in_data_i.col3_y) && (in_data_i.col3_y <= in_data_i.col3_w) &&
      (nw <= in_data_i.col3_z) && (in_data_i.col3_z <= in_data_i.col3_w);
    // Full 64-bit signed products: the 64-bit target widens both operands.
    job_d.px_x = in_data_i.col0_x * width_i;
    job_d.px_y = in_data_i.col0_y * width_i;
    job_d.px_z = in_data_i.col0_z * width_i;
    job_d.px_w = in_data_i.col0_w * width_i;
    job_d.py_x = in_data_i.col1_x * height_i;
    job_d.py_y = in_data_i.col1_y * height_i;
    job_d.py_z = in_data_i.col1_z * height_i;
    job_d.py_w = in_data_i.col1_w * height_i;
    // Translation scaled by 2^(FRAC_BITS+1): a shift, exact in 64 bits.
    job_d.pt_x = ProdW'(in_data_i.col3_x) <<< (FRAC_BITS + 1);
    job_d.pt_y = ProdW'(in_data_i.col3_y) <<< (FRAC_BITS + 1);
    job_d.pt_z = ProdW'(in_data_i.col3_z) <<< (FRAC_BITS + 1);
    job_d.pt_w = ProdW'(in_data_i.col3_w) <<< (FRAC_BITS + 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q <= job_d;
    end
  end
endmodule
`default_nettype wire

FILE: src/qcsc_queue.sv
// qcsc_queue: two-entry queue between front and back ends.
// Depends on qcsc_pkg.
`default_nettype none
module qcsc_queue import qcsc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_valid_i,
  output logic           wr_ready_o,
  input  wire qcsc_job_t wr_data_i,
  output logic           rd_valid_o,
  input  wire logic      rd_ready_i,
  output qcsc_job_t      rd_data_o
);
  qcsc_job_t mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic      wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

FILE: src/qcsc_back.sv
// qcsc_back: forms corner components, plane tests and the cull decision.
// Depends on qcsc_pkg.
`default_nettype none
module qcsc_back import qcsc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      job_valid_i,
  output logic           job_ready_o,
  input  wire qcsc_job_t job_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output logic           res_culled_o
);
  logic       valid_q, culled_q, culled_d;
  logic [3:0] in_l, in_r, in_t, in_b;
  logic       any_in;
  logic signed [CompW-1:0] cx, cy, cz, cw;

  function automatic logic signed [CompW-1:0] comp(
    input logic signed [ProdW-1:0] px, py, pt, input logic sx, sy);
    logic signed [CompW-1:0] a, b;
    a = sx ? -CompW'(px) : CompW'(px);
    b = sy ? -CompW'(py) : CompW'(py);
    return a + b + CompW'(pt);
  endfunction

  always_comb begin
    any_in = 1'b0;
    for (int k = 0; k < 4; k++) begin
      // Corner signs: (-,-), (+,+), (-,+), (+,-).
      logic sx, sy;
      sx = (k == 0) || (k == 2);
      sy = (k == 0) || (k == 3);
      cx = comp(job_i.px_x, job_i.py_x, job_i.pt_x, sx, sy);
      cy = comp(job_i.px_y, job_i.py_y, job_i.pt_y, sx, sy);
      cz = comp(job_i.px_z, job_i.py_z, job_i.pt_z, sx, sy);
      cw = comp(job_i.px_w, job_i.py_w, job_i.pt_w, sx, sy);
      in_l[k] = (cx + cw) >= 0;
      in_r[k] = (cw - cx) >= 0;
      in_t[k] = (cy + cw) >= 0;
      in_b[k] = (cw - cy) >= 0;
      if (in_l[k] && in_r[k] && in_t[k] && in_b[k] &&
          ((cz + cw) >= 0) && ((cw - cz) >= 0)) any_in = 1'b1;
    end
    if (job_i.trans_in || any_in) culled_d = 1'b0;
    else if (in_l == 4'd0 || in_r == 4'd0 || in_t == 4'd0 || in_b == 4'd0)
      culled_d = 1'b1;
    else culled_d = &{in_l, in_r, in_t, in_b};
  end

  assign job_ready_o  = !valid_q || res_ready_i;
  assign res_valid_o  = valid_q;
  assign res_culled_o = culled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (job_ready_o) begin
      valid_q <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready_o && job_valid_i) culled_q <= culled_d;
  end
endmodule
`default_nettype wire

FILE: src/quad_clip_space_cull_core.sv
// quad_clip_space_cull_core: top level of the clip-space rectangle cull.
// Depends on qcsc_pkg, qcsc_if, qcsc_front, qcsc_queue, qcsc_back.
//
//  channel   dir  payload                          handshake
//  in_if     in   col0_*, col1_*, col3_* (12x32)   valid/ready
//  out_if    out  culled (1 bit)                   valid/ready
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i  write strobe
//
// One item per cycle while the output is ready; items pass the product
// register, queue and decision register in turn. Reset clears valid flags,
// the queue and the size registers. Output stalls fill the two-entry queue
// before the input ready drops; the front accepts while the back end waits.
`default_nettype none
module quad_clip_space_cull_core import qcsc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  qcsc_if.sink                  in_if,
  qcsc_res_if.source            out_if,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [WordW-1:0] cfg_data_i
);
  logic signed [WordW-1:0] width_q, height_q;
  logic      f_valid, f_ready, b_valid, b_ready;
  qcsc_job_t f_job, b_job;

  // Hold the size registers; drop writes to anything else.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  qcsc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .width_i(width_q), .height_i(height_q),
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  qcsc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_job)
  );

  qcsc_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready),
    .res_culled_o(out_if.culled)
  );
endmodule
`default_nettype wire
